>>> rtl/rgbycc_pkg.sv
// Shared constants and types for the RGB to YCbCr 4:2:0 macroblock converter.
// No dependencies; the front, queue, back and top-level files in rtl/ import this package.
package rgbycc_pkg;

  localparam int PIX_W    = 8;                  // one color component
  localparam int SUM_W    = PIX_W + 1;          // sum of a horizontal pair
  localparam int QUAD_W   = PIX_W + 2;          // sum of a 2x2 group
  localparam int POS_W    = 8;                  // raster index in a 16x16 macroblock
  localparam int CCOLS    = 8;                  // chroma columns per macroblock
  localparam int CIDX_W   = $clog2(CCOLS);
  localparam int QDEPTH   = 4;                  // front-to-back queue depth
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [POS_W-1:0] LAST_POS = '1;   // 256th pixel

  typedef logic [PIX_W-1:0] pix_t;

  // Horizontal pair sums kept for the even row of a chroma line
  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } pair_sum_t;

  // Work item handed from the front to the back
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             chroma;
    pix_t             red;
    pix_t             green;
    pix_t             blue;
    pix_t             avg_red;
    pix_t             avg_green;
    pix_t             avg_blue;
  } q_item_t;

endpackage

>>> rtl/rgbycc_if.sv
// Valid/ready channel interfaces for pixels in and YCbCr results out.
// No dependencies.
interface rgbycc_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbycc_res_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] luma;
  logic [1:0]        luma_block;
  logic [2:0]        luma_row;
  logic [2:0]        luma_col;
  logic              chroma_valid;
  logic signed [7:0] chroma_blue;
  logic signed [7:0] chroma_red;
  logic [2:0]        chroma_row;
  logic [2:0]        chroma_col;
  logic              macroblock_done;

  modport source (
    output valid, output luma, output luma_block, output luma_row, output luma_col,
    output chroma_valid, output chroma_blue, output chroma_red, output chroma_row,
    output chroma_col, output macroblock_done, input ready
  );
  modport sink (
    input valid, input luma, input luma_block, input luma_row, input luma_col,
    input chroma_valid, input chroma_blue, input chroma_red, input chroma_row,
    input chroma_col, input macroblock_done, output ready
  );
endinterface

>>> rtl/rgbycc_front.sv
// Front end: accepts pixels, tracks raster position, builds 2x2 group averages.
// Depends on rgbycc_pkg and rgbycc_pix_if.
module rgbycc_front (
  input  logic                clk,
  input  logic                rst_n,
  rgbycc_pix_if.sink          pix,
  input  logic                q_full,
  output logic                push,
  output rgbycc_pkg::q_item_t push_item
);
  import rgbycc_pkg::*;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  pix_t              left_red_r, left_green_r, left_blue_r;
  pair_sum_t         pair_line_r [CCOLS];

  logic              xfer;
  logic [3:0]        row, col;
  logic [CIDX_W-1:0] idx;
  pair_sum_t         pair, line;
  logic [QUAD_W-1:0] quad_red, quad_green, quad_blue;

  assign pix.ready = !q_full;
  assign xfer      = pix.valid && pix.ready;
  assign push      = xfer;

  assign row = pos_r[7:4];
  assign col = pos_r[3:0];
  assign idx = col[3:1];

  always_comb begin
    pair.red   = {1'b0, left_red_r}   + {1'b0, pix.red};
    pair.green = {1'b0, left_green_r} + {1'b0, pix.green};
    pair.blue  = {1'b0, left_blue_r}  + {1'b0, pix.blue};
    line       = pair_line_r[idx];
    quad_red   = {1'b0, line.red}   + {1'b0, pair.red};
    quad_green = {1'b0, line.green} + {1'b0, pair.green};
    quad_blue  = {1'b0, line.blue}  + {1'b0, pair.blue};
  end

  always_comb begin
    push_item.pos       = pos_r;
    push_item.chroma    = col[0] && row[0];
    push_item.red       = pix.red;
    push_item.green     = pix.green;
    push_item.blue      = pix.blue;
    push_item.avg_red   = quad_red[QUAD_W-1:2];
    push_item.avg_green = quad_green[QUAD_W-1:2];
    push_item.avg_blue  = quad_blue[QUAD_W-1:2];
  end

  always_comb begin
    pos_nxt = xfer ? pos_r + 1'b1 : pos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Hold the even-column pixel; store pair sums on even rows
  always_ff @(posedge clk) begin
    if (xfer && !col[0]) begin
      left_red_r   <= pix.red;
      left_green_r <= pix.green;
      left_blue_r  <= pix.blue;
    end
    if (xfer && col[0] && !row[0]) begin
      pair_line_r[idx] <= pair;
    end
  end

endmodule

>>> rtl/rgbycc_fifo.sv
// Short queue of work items between the front and back ends.
// Depends on rgbycc_pkg.
module rgbycc_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rgbycc_pkg::q_item_t push_item,
  output logic                full,
  input  logic                pop,
  output rgbycc_pkg::q_item_t pop_item,
  output logic                empty
);
  import rgbycc_pkg::*;

  q_item_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == QCNT_W'(QDEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> rtl/rgbycc_back.sv
// Back end: color-space arithmetic and the registered result stage.
// Depends on rgbycc_pkg and rgbycc_res_if.
module rgbycc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  rgbycc_pkg::q_item_t q_item,
  output logic                pop,
  rgbycc_res_if.source        res
);
  import rgbycc_pkg::*;

  function automatic pix_t luma_f(input pix_t r, input pix_t g, input pix_t b);
    logic [16:0] s;
    s = 17'd153 * {9'd0, r} + 17'd301 * {9'd0, g} + 17'd58 * {9'd0, b};
    return s[16:9];
  endfunction

  // Final values stay in 0..255, so modular 18-bit arithmetic is exact
  function automatic pix_t cb_f(input pix_t r, input pix_t g, input pix_t b);
    logic [17:0] s;
    s = 18'd65536 + {2'd0, b, 8'd0} - 18'd86 * {10'd0, r} - 18'd170 * {10'd0, g};
    return s[16:9];
  endfunction

  function automatic pix_t cr_f(input pix_t r, input pix_t g, input pix_t b);
    logic [17:0] s;
    s = 18'd65536 + {2'd0, r, 8'd0} - 18'd214 * {10'd0, g} - 18'd42 * {10'd0, b};
    return s[16:9];
  endfunction

  function automatic pix_t shift_f(input pix_t v);
    return {~v[PIX_W-1], v[PIX_W-2:0]};
  endfunction

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  luma_r, cb_r, cr_r;
  logic [1:0]  block_r;
  logic [2:0]  row_r, col_r, crow_r, ccol_r;
  logic        chroma_r, done_r;

  logic [3:0]  row, col;
  pix_t        y, cb, cr;

  assign pop = !q_empty && (!out_valid_r || res.ready);

  assign row = q_item.pos[7:4];
  assign col = q_item.pos[3:0];

  always_comb begin
    y  = shift_f(luma_f(q_item.red, q_item.green, q_item.blue));
    cb = shift_f(cb_f(q_item.avg_red, q_item.avg_green, q_item.avg_blue));
    cr = shift_f(cr_f(q_item.avg_red, q_item.avg_green, q_item.avg_blue));
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      luma_r   <= y;
      block_r  <= {row[3], col[3]};
      row_r    <= row[2:0];
      col_r    <= col[2:0];
      chroma_r <= q_item.chroma;
      cb_r     <= q_item.chroma ? cb : 8'd0;
      cr_r     <= q_item.chroma ? cr : 8'd0;
      crow_r   <= q_item.chroma ? row[3:1] : 3'd0;
      ccol_r   <= q_item.chroma ? col[3:1] : 3'd0;
      done_r   <= (q_item.pos == LAST_POS);
    end
  end

  assign res.valid           = out_valid_r;
  assign res.luma            = luma_r;
  assign res.luma_block      = block_r;
  assign res.luma_row        = row_r;
  assign res.luma_col        = col_r;
  assign res.chroma_valid    = chroma_r;
  assign res.chroma_blue     = cb_r;
  assign res.chroma_red      = cr_r;
  assign res.chroma_row      = crow_r;
  assign res.chroma_col      = ccol_r;
  assign res.macroblock_done = done_r;

endmodule

>>> rtl/rgb_macroblock_to_ycbcr_420.sv
// Top level: RGB macroblock to level-shifted YCbCr with 4:2:0 chroma.
// Depends on rgbycc_pkg, rgbycc_if, rgbycc_front, rgbycc_fifo, rgbycc_back.
//
//  channel   direction  handshake         payload
//  in_pix    in         valid / ready     red, green, blue (8 bits each)
//  out_res   out        valid / ready     luma + block/row/col, Cb/Cr + row/col, done
//
// One pixel per clock sustained while out_res is not stalled: a pixel crosses
// the front (position counter, held left pixel, 8-entry pair-sum line) and
// lands in a 4-entry queue the same cycle; the back computes Y, Cb and Cr
// from the queue head into the output register.
// Reset clears the raster position, queue and output valid; the left pixel
// and the pair-sum line need no clearing since raster order writes each entry
// before it is read. A stalled output holds its result; the front keeps
// taking pixels until the queue fills, then drops ready.
module rgb_macroblock_to_ycbcr_420 (
  input logic           clk,
  input logic           rst_n,
  rgbycc_pix_if.sink    in_pix,
  rgbycc_res_if.source  out_res
);
  import rgbycc_pkg::*;

  logic    q_full, q_empty, q_push, q_pop;
  q_item_t q_in, q_out;

  // Classify the pixel and build group averages
  rgbycc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix       (in_pix),
    .q_full    (q_full),
    .push      (q_push),
    .push_item (q_in)
  );

  // Decouple the input side from output stalls
  rgbycc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out),
    .empty     (q_empty)
  );

  // Color conversion and result register
  rgbycc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_item  (q_out),
    .pop     (q_pop),
    .res     (out_res)
  );

endmodule

>>> rtl/rgbycc_checker.sv
// Port-level checks for the macroblock converter, bound to the top level.
// Depends on rgb_macroblock_to_ycbcr_420 and its interface ports.
module rgbycc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_luma,
  input logic [1:0] out_luma_block,
  input logic [2:0] out_luma_row,
  input logic [2:0] out_luma_col,
  input logic       out_chroma_valid,
  input logic [7:0] out_chroma_blue,
  input logic [7:0] out_chroma_red,
  input logic [2:0] out_chroma_row,
  input logic [2:0] out_chroma_col,
  input logic       out_done
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_luma) && $stable(out_luma_row)
      && $stable(out_luma_col) && $stable(out_chroma_blue) && $stable(out_chroma_red))
    else $error("stalled result changed");

  // Chroma only on the odd-row, odd-column pixel of a group
  a_chroma_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_chroma_valid |-> out_luma_row[0] && out_luma_col[0])
    else $error("chroma on wrong pixel");

  // Chroma coordinates follow the luma coordinates
  a_chroma_coord: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_chroma_valid |->
      out_chroma_row == {out_luma_block[1], out_luma_row[2:1]} &&
      out_chroma_col == {out_luma_block[0], out_luma_col[2:1]})
    else $error("chroma coordinates mismatch");

  // Unused chroma fields are zero
  a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_chroma_valid |->
      out_chroma_blue == 8'd0 && out_chroma_red == 8'd0 &&
      out_chroma_row == 3'd0 && out_chroma_col == 3'd0)
    else $error("chroma fields not cleared");

  // Done marks the bottom-right pixel only
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_done == (out_luma_block == 2'd3 && out_luma_row == 3'd7 &&
      out_luma_col == 3'd7))
    else $error("macroblock done misplaced");

endmodule

bind rgb_macroblock_to_ycbcr_420 rgbycc_checker u_rgbycc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_res.valid),
  .out_ready        (out_res.ready),
  .out_luma         (out_res.luma),
  .out_luma_block   (out_res.luma_block),
  .out_luma_row     (out_res.luma_row),
  .out_luma_col     (out_res.luma_col),
  .out_chroma_valid (out_res.chroma_valid),
  .out_chroma_blue  (out_res.chroma_blue),
  .out_chroma_red   (out_res.chroma_red),
  .out_chroma_row   (out_res.chroma_row),
  .out_chroma_col   (out_res.chroma_col),
  .out_done         (out_res.macroblock_done)
);
